FILE: rtl/transform_matrix_builder_core_defines.svh
// assertion macros shared by the transform matrix builder rtl
// no dependencies
`ifndef TRANSFORM_MATRIX_BUILDER_CORE_DEFINES_SVH
`define TRANSFORM_MATRIX_BUILDER_CORE_DEFINES_SVH
`define TMB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/tmb_pkg.sv
// package for the transform matrix builder: widths, cordic table, helpers
// no dependencies
package tmb_pkg;
   localparam int FracBitsDefault  = 16;
   localparam int AngleBitsDefault = 16;
   localparam int CordicSteps      = 30;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam int DataW = 32;

   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      logic signed [33:0] v;
      begin
         unique case (i)
            5'd0: v = 34'sd536870912;   5'd1: v = 34'sd316933406;
            5'd2: v = 34'sd167458907;   5'd3: v = 34'sd85004756;
            5'd4: v = 34'sd42667331;    5'd5: v = 34'sd21354465;
            5'd6: v = 34'sd10679838;    5'd7: v = 34'sd5340245;
            5'd8: v = 34'sd2670163;     5'd9: v = 34'sd1335087;
            5'd10: v = 34'sd667544;     5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;     5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;      5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;      5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;       5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;        5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;        5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;         5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;         5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;          5'd29: v = 34'sd1;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      logic signed [31:0] r;
      begin
         if (v > 80'sh7FFFFFFF) r = 32'sh7FFFFFFF;
         else if (v < -80'sh80000000) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction

   // round q2.30 product back to q2.30 scale
   function automatic logic signed [79:0] rnd30(input logic signed [79:0] p);
      return (p + 80'sd536870912) >>> 30;
   endfunction

   // trig results of one word, q2.30
   typedef struct packed {
      logic signed [31:0] ca, sa, cb, sb, cc, sc;
   } trig_type;
endpackage

FILE: rtl/transform_matrix_builder_core.sv
// transform matrix builder: an accepted word passes the stages below, in order, to its first output element
// angle fold stage, 30 cordic stages, 5 product stages, matrix load, output register
// the single element output channel limits the flow, since each matrix goes out one element at a time
// the pipeline takes a new word each cycle unless a finished matrix waits for the serializer
// synchronous active-high reset clears all valid bits; payload registers are not reset
`include "transform_matrix_builder_core_defines.svh"
module transform_matrix_builder_core
   import tmb_pkg::*;
#(
   parameter int FRAC_BITS  = FracBitsDefault,
   parameter int ANGLE_BITS = AngleBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   input  logic signed [31:0]    req_pos_z,
   input  logic signed [31:0]    req_org_x,
   input  logic signed [31:0]    req_org_y,
   input  logic signed [31:0]    req_org_z,
   input  logic signed [31:0]    req_scl_x,
   input  logic signed [31:0]    req_scl_y,
   input  logic signed [31:0]    req_scl_z,
   input  logic [ANGLE_BITS-1:0] req_angle_a,
   input  logic [ANGLE_BITS-1:0] req_angle_b,
   input  logic [ANGLE_BITS-1:0] req_angle_c,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_element,
   output logic [1:0]            rsp_row,
   output logic [1:0]            rsp_col,
   output logic                  rsp_last
);
   localparam int CD = CordicSteps + 1;
   localparam int NP = 5;
   localparam int DEPTH = CD + NP;

   typedef struct packed {
      logic signed [31:0] px, py, pz, ox, oy, oz, sx, sy, sz;
   } geo_type;

   // whole pipeline moves together when its tail is empty or can unload
   logic advance;
   logic tail_free;
   logic [DEPTH-1:0] vld_ff;
   geo_type geo_ff [CD];
   trig_type trig;

   assign advance   = !vld_ff[DEPTH-1] || tail_free;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         geo_ff[0] <= '{req_pos_x, req_pos_y, req_pos_z, req_org_x, req_org_y,
                        req_org_z, req_scl_x, req_scl_y, req_scl_z};
         for (int i = 1; i < CD; i++) geo_ff[i] <= geo_ff[i-1];
      end
   end

   tmb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock   (clock),
      .advance (advance),
      .ang_a   (req_angle_a),
      .ang_b   (req_angle_b),
      .ang_c   (req_angle_c),
      .trig    (trig)
   );

   // p1: first products and translation
   geo_type g1_ff, g2_ff, g3_ff, g4_ff;
   logic signed [31:0] sb1_ff, cc1_ff, sc1_ff;
   logic signed [31:0] casb_ff, sasb_ff, r00_ff, r10_ff, r21_ff, r22_ff;
   logic signed [31:0] sacc_ff, sasc_ff, cacc_ff, casc_ff;
   logic signed [31:0] t_ff [3];
   // p2
   logic signed [31:0] r01_ff, r02_ff, r11_ff, r12_ff, r20_ff;
   logic signed [31:0] q00_ff, q10_ff, q21_ff, q22_ff;
   logic signed [31:0] ta_ff [3];
   // p3: matrix products
   logic signed [79:0] m_ff [3][3];
   logic signed [79:0] tr_ff [3][3];
   // p4: sums
   logic signed [31:0] e_ff [3][3];
   logic signed [79:0] acc_ff [3];
   logic signed [31:0] row3_ff [3];
   logic signed [31:0] e5_ff [3][3];

   logic signed [79:0] rw [3][3];
   logic signed [31:0] ov [3];

   always_comb begin
      rw[0][0] = 80'(q00_ff); rw[0][1] = 80'(r01_ff); rw[0][2] = 80'(r02_ff);
      rw[1][0] = 80'(q10_ff); rw[1][1] = 80'(r11_ff); rw[1][2] = 80'(r12_ff);
      rw[2][0] = 80'(r20_ff); rw[2][1] = 80'(q21_ff); rw[2][2] = 80'(q22_ff);
      ov[0] = geo_ff[CD-1].ox; ov[1] = geo_ff[CD-1].oy; ov[2] = geo_ff[CD-1].oz;
   end

   logic signed [31:0] svg [3];
   assign svg[0] = geo_ff[CD-1].sx;
   assign svg[1] = geo_ff[CD-1].sy;
   assign svg[2] = geo_ff[CD-1].sz;
   logic signed [31:0] sv2 [3];
   assign sv2[0] = g2_ff.sx;
   assign sv2[1] = g2_ff.sy;
   assign sv2[2] = g2_ff.sz;

   always_ff @(posedge clock) begin
      if (advance) begin
         // stage p1
         g1_ff  <= geo_ff[CD-1];
         casb_ff <= 32'(rnd30(80'(trig.ca) * 80'(trig.sb)));
         sasb_ff <= 32'(rnd30(80'(trig.sa) * 80'(trig.sb)));
         r00_ff <= 32'(rnd30(80'(trig.ca) * 80'(trig.cb)));
         r10_ff <= 32'(rnd30(80'(trig.sa) * 80'(trig.cb)));
         r21_ff <= 32'(rnd30(80'(trig.cb) * 80'(trig.sc)));
         r22_ff <= 32'(rnd30(80'(trig.cb) * 80'(trig.cc)));
         sacc_ff <= 32'(rnd30(80'(trig.sa) * 80'(trig.cc)));
         sasc_ff <= 32'(rnd30(80'(trig.sa) * 80'(trig.sc)));
         cacc_ff <= 32'(rnd30(80'(trig.ca) * 80'(trig.cc)));
         casc_ff <= 32'(rnd30(80'(trig.ca) * 80'(trig.sc)));
         sb1_ff <= trig.sb; cc1_ff <= trig.cc; sc1_ff <= trig.sc;
         for (int k = 0; k < 3; k++) begin
            t_ff[k] <= sat32((-(80'(ov[k]) * 80'(svg[k]))
                              + (80'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
         end
         // stage p2: triple products
         g2_ff  <= g1_ff;
         r01_ff <= 32'(rnd30(80'(casb_ff) * 80'(sc1_ff)) - 80'(sacc_ff));
         r02_ff <= 32'(rnd30(80'(casb_ff) * 80'(cc1_ff)) + 80'(sasc_ff));
         r11_ff <= 32'(rnd30(80'(sasb_ff) * 80'(sc1_ff)) + 80'(cacc_ff));
         r12_ff <= 32'(rnd30(80'(sasb_ff) * 80'(cc1_ff)) - 80'(casc_ff));
         r20_ff <= -sb1_ff;
         q00_ff <= r00_ff; q10_ff <= r10_ff; q21_ff <= r21_ff; q22_ff <= r22_ff;
         ta_ff <= t_ff;
         // stage p3: element products
         g3_ff <= g2_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               m_ff[i][j]  <= 80'(sv2[i]) * rw[i][j];
               tr_ff[i][j] <= 80'(ta_ff[i]) * rw[i][j];
            end
         end
         // stage p4: saturate scale products, sum translation rows
         g4_ff <= g3_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) e_ff[i][j] <= sat32(rnd30(m_ff[i][j]));
         end
         for (int j = 0; j < 3; j++) acc_ff[j] <= tr_ff[0][j] + tr_ff[1][j] + tr_ff[2][j];
         // stage p5: last row
         e5_ff <= e_ff;
         row3_ff[0] <= sat32(rnd30(acc_ff[0]) + 80'(g4_ff.px));
         row3_ff[1] <= sat32(rnd30(acc_ff[1]) + 80'(g4_ff.py));
         row3_ff[2] <= sat32(rnd30(acc_ff[2]) + 80'(g4_ff.pz));
      end
   end

   // serializer: holds one full matrix and walks it out
   logic signed [31:0] mat_ff [16];
   logic               busy_ff;
   logic [3:0]         idx_ff;
   logic               out_vld_ff;
   logic signed [31:0] out_el_ff;
   logic [3:0]         out_idx_ff;
   logic               load;
   logic               emit;
   logic               out_free;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign tail_free = !busy_ff || (emit && idx_ff == 4'd15);
   assign load      = vld_ff[DEPTH-1] && tail_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         idx_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (out_free) out_vld_ff <= emit;
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (emit) begin
            idx_ff <= idx_ff + 4'd1;
            if (idx_ff == 4'd15) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) mat_ff[i*4+j] <= e5_ff[i][j];
            mat_ff[i*4+3] <= '0;
            mat_ff[12+i]  <= row3_ff[i];
         end
         mat_ff[15] <= 32'sd1 <<< FRAC_BITS;
      end
      if (emit) begin
         out_el_ff  <= mat_ff[idx_ff];
         out_idx_ff <= idx_ff;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_element = out_el_ff;
   assign rsp_row     = out_idx_ff[3:2];
   assign rsp_col     = out_idx_ff[1:0];
   assign rsp_last    = out_idx_ff == 4'd15;

   `TMB_ASSERT_IMPL(a_load_idle, clock, reset, load && busy_ff, emit && idx_ff == 4'd15,
      "matrix loaded over unfinished one")
   `TMB_ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_element) && $stable(out_idx_ff), "stalled word changed")
   `TMB_ASSERT_NEXT(a_load_start, clock, reset, load, busy_ff && idx_ff == 4'd0,
      "serializer did not start at element zero")
endmodule

FILE: rtl/tmb_cordic.sv
// pipelined cordic sine/cosine for three angles, one step per stage
// depends on tmb_pkg
module tmb_cordic
   import tmb_pkg::*;
#(
   parameter int ANGLE_BITS = AngleBitsDefault
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [ANGLE_BITS-1:0] ang_a,
   input  logic [ANGLE_BITS-1:0] ang_b,
   input  logic [ANGLE_BITS-1:0] ang_c,
   output trig_type              trig
);
   localparam int NS = CordicSteps;

   logic signed [33:0] x_ff [3][NS+1];
   logic signed [33:0] y_ff [3][NS+1];
   logic signed [33:0] z_ff [3][NS+1];
   logic               n_ff [3][NS+1];

   logic [ANGLE_BITS-1:0] ang [3];
   assign ang[0] = ang_a;
   assign ang[1] = ang_b;
   assign ang[2] = ang_c;

   for (genvar a = 0; a < 3; a++) begin : g_ax
      logic signed [33:0] z0;
      logic signed [33:0] zf;
      logic               nf;
      always_comb begin
         z0 = 34'(signed'({ang[a], {(32-ANGLE_BITS){1'b0}}}));
         zf = z0;
         nf = 1'b0;
         if (z0 > 34'sd1073741824) begin
            zf = z0 - 34'sd2147483648;
            nf = 1'b1;
         end else if (z0 < -34'sd1073741824) begin
            zf = z0 + 34'sd2147483648;
            nf = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[a][0] <= CordicGain;
            y_ff[a][0] <= '0;
            z_ff[a][0] <= zf;
            n_ff[a][0] <= nf;
         end
      end
      for (genvar s = 0; s < NS; s++) begin : g_st
         logic signed [33:0] dx, dy;
         assign dx = y_ff[a][s] >>> s;
         assign dy = x_ff[a][s] >>> s;
         always_ff @(posedge clock) begin
            if (advance) begin
               n_ff[a][s+1] <= n_ff[a][s];
               if (!z_ff[a][s][33]) begin
                  x_ff[a][s+1] <= x_ff[a][s] - dx;
                  y_ff[a][s+1] <= y_ff[a][s] + dy;
                  z_ff[a][s+1] <= z_ff[a][s] - atan_turn(5'(s));
               end else begin
                  x_ff[a][s+1] <= x_ff[a][s] + dx;
                  y_ff[a][s+1] <= y_ff[a][s] - dy;
                  z_ff[a][s+1] <= z_ff[a][s] + atan_turn(5'(s));
               end
            end
         end
      end
   end

   logic signed [33:0] co [3];
   logic signed [33:0] si [3];
   for (genvar a = 0; a < 3; a++) begin : g_out
      assign co[a] = n_ff[a][NS] ? -x_ff[a][NS] : x_ff[a][NS];
      assign si[a] = n_ff[a][NS] ? -y_ff[a][NS] : y_ff[a][NS];
   end
   assign trig.ca = co[0][31:0];
   assign trig.sa = si[0][31:0];
   assign trig.cb = co[1][31:0];
   assign trig.sb = si[1][31:0];
   assign trig.cc = co[2][31:0];
   assign trig.sc = si[2][31:0];
endmodule
